// ===== sv/ssba_pkg.sv =====
// Shared types, constants and helper functions of the slab slot bitmap allocator.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package ssba_pkg;

   localparam int WORD_BITS        = 32;
   localparam int WORD_IDX_W       = $clog2(WORD_BITS);
   localparam int SLOT_W           = 8;
   localparam int SLOT_REACH       = 256;
   localparam int LIMIT_W          = 9;
   localparam int OBJ_W            = 16;
   localparam int CSR_DATA_W       = 32;
   localparam int CSR_ADDR_W       = 3;
   localparam int DEF_MAX_SLOTS    = 256;
   localparam int DEF_HEADER_BYTES = 64;

   localparam logic [LIMIT_W-1:0] RST_SLOT_COUNT   = 9'd256;
   localparam logic [OBJ_W-1:0]   RST_OBJECT_BYTES = 16'd64;

   typedef enum logic [2:0] {
      ACT_INIT      = 3'd0,
      ACT_SET       = 3'd1,
      ACT_CLEAR     = 3'd2,
      ACT_TEST      = 3'd3,
      ACT_FIND_FREE = 3'd4,
      ACT_FIND_USED = 3'd5
   } action_type;

   typedef enum logic {
      CSR_SLOT_COUNT   = 1'b0,
      CSR_OBJECT_BYTES = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_FILL,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]        action;
      logic [SLOT_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic              bit_value;
      logic              found;
      logic [SLOT_W-1:0] found_slot;
      logic              error;
   } rsp_type;

   // Bits of the word starting at slot base whose slot index lies below limit.
   function automatic logic [WORD_BITS-1:0] below_mask(input logic [LIMIT_W-1:0] limit,
                                                       input logic [LIMIT_W-1:0] base);
      logic [LIMIT_W-1:0]   diff;
      logic [WORD_BITS-1:0] m;
      diff = limit - base;
      if (limit <= base) begin
         m = '0;
      end else if (diff >= LIMIT_W'(WORD_BITS)) begin
         m = '1;
      end else begin
         m = (WORD_BITS'(1) << diff[WORD_IDX_W-1:0]) - WORD_BITS'(1);
      end
      return m;
   endfunction

   // Position of the lowest set bit; zero when no bit is set.
   function automatic logic [WORD_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
      logic [WORD_IDX_W-1:0] p;
      p = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (w[i]) begin
            p = WORD_IDX_W'(i);
         end
      end
      return p;
   endfunction

endpackage

`default_nettype wire

// ===== sv/ssba_divider.sv =====
// Restoring divider, one quotient bit per cycle, used to size the header at init.
// Depends on ssba_pkg for the divisor width.
`default_nettype none

module ssba_divider #(
   parameter int DW = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [DW-1:0]              dividend,
   input  wire logic [ssba_pkg::OBJ_W-1:0] divisor,
   output logic                            busy,
   output logic [DW-1:0]                   quotient,
   output logic [ssba_pkg::OBJ_W-1:0]      remainder
);

   localparam int CW = $clog2(DW + 1);
   localparam int OW = ssba_pkg::OBJ_W;

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [OW-1:0] rem_ff, rem_in;
   logic [OW-1:0] div_ff, div_in;

   logic [OW:0]   shifted;
   logic [OW:0]   diff;
   logic          ge;

   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign ge      = shifted >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // shift the next dividend bit in, subtract when it fits
         quo_in = DW'({quo_ff, ge});
         rem_in = ge ? diff[OW-1:0] : shifted[OW-1:0];
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== sv/ssba_store.sv =====
// Occupancy word store: one write port and one read port, cleared by reset.
// Depends on ssba_pkg for the word width.
`default_nettype none

module ssba_store #(
   parameter int WORDS = 8,
   parameter int IDX_W = 3
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           wr_en,
   input  wire logic [IDX_W-1:0]               wr_idx,
   input  wire logic [ssba_pkg::WORD_BITS-1:0] wr_word,
   input  wire logic [IDX_W-1:0]               rd_idx,
   output logic [ssba_pkg::WORD_BITS-1:0]      rd_word
);

   logic [ssba_pkg::WORD_BITS-1:0] words_ff [WORDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WORDS; i++) begin
            words_ff[i] <= '0;
         end
      end else if (wr_en) begin
         words_ff[wr_idx] <= wr_word;
      end
   end

   assign rd_word = words_ff[rd_idx];

endmodule

`default_nettype wire

// ===== sv/slab_slot_bitmap_allocator_core.sv =====
// Slab slot bitmap allocator: init, set, clear, test and lowest-free/lowest-used search over slots.
// Searches scan one 32-bit word per cycle; init sizes the header with the divider, then rewrites
// every map word. A new request is accepted only in idle, after the result of the last one is
// registered, so requests never overlap; only a result still stalled in the register holds the
// sequencer.
// Synchronous active-high reset clears the map and the FSM and restores 256 slots, 64 B objects.
`default_nettype none

module slab_slot_bitmap_allocator_core #(
   parameter int MAX_SLOTS    = ssba_pkg::DEF_MAX_SLOTS,
   parameter int HEADER_BYTES = ssba_pkg::DEF_HEADER_BYTES
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire ssba_pkg::req_type                req_payload,
   // result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output ssba_pkg::rsp_type                     rsp_payload,
   // configuration port
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [ssba_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [ssba_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ssba_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   localparam int WB        = ssba_pkg::WORD_BITS;
   localparam int LW        = ssba_pkg::LIMIT_W;
   localparam int OW        = ssba_pkg::OBJ_W;
   localparam int NUM_WORDS = (MAX_SLOTS + WB - 1) / WB;
   // slots past the 8-bit slot reach are never touched
   localparam int REACH_W   = ssba_pkg::SLOT_REACH / WB;
   localparam int WORDS     = (NUM_WORDS > REACH_W) ? REACH_W : NUM_WORDS;
   localparam int IDX_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CAP       = (MAX_SLOTS > ssba_pkg::SLOT_REACH) ? ssba_pkg::SLOT_REACH
                                                                : MAX_SLOTS;
   // dividend holds header bytes plus map word count
   localparam int DW        = $clog2(HEADER_BYTES + WORDS + 1);
   localparam int HW        = (DW + 1 > LW) ? DW + 1 : LW;

   // ---------------------------------------------------------------- config
   logic [LW-1:0] slot_count_ff, slot_count_in;
   logic [OW-1:0] object_bytes_ff, object_bytes_in;
   logic          csr_write;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      slot_count_in   = slot_count_ff;
      object_bytes_in = object_bytes_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            ssba_pkg::CSR_SLOT_COUNT:   slot_count_in   = csr_pwdata[LW-1:0];
            ssba_pkg::CSR_OBJECT_BYTES: object_bytes_in = csr_pwdata[OW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         ssba_pkg::CSR_SLOT_COUNT:   csr_prdata = ssba_pkg::CSR_DATA_W'(slot_count_ff);
         ssba_pkg::CSR_OBJECT_BYTES: csr_prdata = ssba_pkg::CSR_DATA_W'(object_bytes_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   ssba_pkg::state_type            state_ff, state_in;
   logic [2:0]                     action_ff, action_in;
   logic [ssba_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [LW-1:0]                  hdr_ff, hdr_in;
   ssba_pkg::rsp_type              res_ff, res_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   ssba_pkg::rsp_type              rsp_payload_ff, rsp_payload_in;

   logic [LW-1:0]                  n;          // usable slot limit
   logic [LW:0]                    n_words;    // map words covering n slots
   logic [DW-1:0]                  total;
   logic [OW-1:0]                  ob;
   logic [IDX_W-1:0]               slot_idx;
   logic [ssba_pkg::WORD_IDX_W-1:0] slot_bit;
   logic                           slot_ok;
   logic [LW-1:0]                  base;
   logic [WB-1:0]                  rd_word;
   logic [WB-1:0]                  cand;
   logic                           last_word;
   logic                           out_free;

   logic                           div_start;
   logic                           div_busy;
   logic [DW-1:0]                  div_quo;
   logic [OW-1:0]                  div_rem;
   logic [HW-1:0]                  hdr_raw;
   logic [LW-1:0]                  hdr_clamped;

   logic                           wr_en;
   logic [IDX_W-1:0]               wr_idx;
   logic [WB-1:0]                  wr_word;
   logic [IDX_W-1:0]               rd_idx;

   assign n        = (slot_count_ff > LW'(CAP)) ? LW'(CAP) : slot_count_ff;
   assign n_words  = ({1'b0, n} + (LW + 1)'(WB - 1)) >> ssba_pkg::WORD_IDX_W;
   assign total    = DW'(HEADER_BYTES) + DW'(n_words);
   // treat a zero object size as one byte
   assign ob       = (object_bytes_ff == '0) ? OW'(1) : object_bytes_ff;
   assign slot_idx = slot_ff[IDX_W + ssba_pkg::WORD_IDX_W - 1:ssba_pkg::WORD_IDX_W];
   assign slot_bit = slot_ff[ssba_pkg::WORD_IDX_W-1:0];
   assign slot_ok  = {1'b0, slot_ff} < n;
   assign base     = LW'({idx_ff, {ssba_pkg::WORD_IDX_W{1'b0}}});
   assign rd_idx   = (state_ff == ssba_pkg::S_EXEC) ? slot_idx : idx_ff;

   // searches look only below the limit; stale bits above it stay hidden
   assign cand = ((action_ff == ssba_pkg::ACT_FIND_USED) ? rd_word : ~rd_word)
                 & ssba_pkg::below_mask(n, base);

   assign last_word = (idx_ff == IDX_W'(WORDS - 1)) ||
                      (({1'b0, base} + (LW + 1)'(WB)) >= {1'b0, n});

   // header = ceil(total / ob), held to the slot limit
   assign hdr_raw     = HW'(div_quo) + HW'(div_rem != '0);
   assign hdr_clamped = (hdr_raw > HW'(n)) ? n : hdr_raw[LW-1:0];

   assign out_free = !rsp_valid_ff || !rsp_stall;

   ssba_divider #(
      .DW (DW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (total),
      .divisor   (ob),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   ssba_store #(
      .WORDS (WORDS),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_word (wr_word),
      .rd_idx  (rd_idx),
      .rd_word (rd_word)
   );

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in  = state_ff;
      action_in = action_ff;
      slot_in   = slot_ff;
      idx_in    = idx_ff;
      hdr_in    = hdr_ff;
      res_in    = res_ff;
      div_start = 1'b0;
      wr_en     = 1'b0;
      wr_idx    = slot_idx;
      wr_word   = rd_word;
      req_stall = (state_ff != ssba_pkg::S_IDLE);

      case (state_ff)
         ssba_pkg::S_IDLE: begin
            if (req_valid) begin
               action_in = req_payload.action;
               slot_in   = req_payload.slot;
               res_in    = '0;
               state_in  = ssba_pkg::S_EXEC;
            end
         end
         ssba_pkg::S_EXEC: begin
            state_in = ssba_pkg::S_DONE;
            case (action_ff)
               ssba_pkg::ACT_INIT: begin
                  div_start = 1'b1;
                  state_in  = ssba_pkg::S_DIV;
               end
               ssba_pkg::ACT_SET: begin
                  // drop sets beyond the limit silently
                  wr_en   = slot_ok;
                  wr_word = rd_word | (WB'(1) << slot_bit);
               end
               ssba_pkg::ACT_CLEAR: begin
                  // refuse the first slot and anything beyond the limit
                  if (slot_ff == '0 || !slot_ok) begin
                     res_in.error = 1'b1;
                  end else begin
                     wr_en   = 1'b1;
                     wr_word = rd_word & ~(WB'(1) << slot_bit);
                  end
               end
               ssba_pkg::ACT_TEST: begin
                  res_in.bit_value = slot_ok && rd_word[slot_bit];
               end
               ssba_pkg::ACT_FIND_FREE, ssba_pkg::ACT_FIND_USED: begin
                  idx_in   = '0;
                  state_in = ssba_pkg::S_SCAN;
               end
               default: ;
            endcase
         end
         ssba_pkg::S_DIV: begin
            if (!div_busy) begin
               hdr_in   = hdr_clamped;
               idx_in   = '0;
               state_in = ssba_pkg::S_FILL;
            end
         end
         ssba_pkg::S_FILL: begin
            // rewrite every word: header bits set, the rest cleared
            wr_en   = 1'b1;
            wr_idx  = idx_ff;
            wr_word = ssba_pkg::below_mask(hdr_ff, base);
            if (idx_ff == IDX_W'(WORDS - 1)) begin
               state_in = ssba_pkg::S_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ssba_pkg::S_SCAN: begin
            if (cand != '0) begin
               res_in.found      = 1'b1;
               res_in.found_slot = ssba_pkg::SLOT_W'({idx_ff, ssba_pkg::lowest_set(cand)});
               state_in          = ssba_pkg::S_DONE;
            end else if (last_word) begin
               state_in = ssba_pkg::S_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ssba_pkg::S_DONE: begin
            // hold until the result register is free
            if (out_free) begin
               state_in = ssba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ssba_pkg::S_IDLE;
         end
      endcase
   end

   // result register parts the sequencer from the consumer
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (state_ff == ssba_pkg::S_DONE && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = res_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ssba_pkg::S_IDLE;
         rsp_valid_ff    <= 1'b0;
         slot_count_ff   <= ssba_pkg::RST_SLOT_COUNT;
         object_bytes_ff <= ssba_pkg::RST_OBJECT_BYTES;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         slot_count_ff   <= slot_count_in;
         object_bytes_ff <= object_bytes_in;
      end
      action_ff      <= action_in;
      slot_ff        <= slot_in;
      idx_ff         <= idx_in;
      hdr_ff         <= hdr_in;
      res_ff         <= res_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------------------------------------------------------- checks
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ssba_pkg::S_EXEC)
      else $error("accepted request did not start execution");

   a_div_only_in_init: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> state_ff == ssba_pkg::S_DIV)
      else $error("divider running outside header sizing");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ssba_pkg::S_EXEC || state_ff == ssba_pkg::S_FILL))
      else $error("map written outside execute or fill");

   a_slot_needs_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found |-> rsp_payload.found_slot == '0)
      else $error("slot reported without a hit");

   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.error |-> !rsp_payload.found && !rsp_payload.bit_value)
      else $error("refused clear carries other flags");

endmodule

`default_nettype wire

// ===== tb/slab_slot_bitmap_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for slab_slot_bitmap_allocator_core: occupancy map predictor,
// request driver with bursts and gaps, stalling result monitor and APB register writes.
// Depends on ssba_pkg and the core RTL only.

module slab_slot_bitmap_allocator_core_tb;

   localparam int SLOT_W     = ssba_pkg::SLOT_W;
   localparam int LIMIT_W    = ssba_pkg::LIMIT_W;
   localparam int OBJ_W      = ssba_pkg::OBJ_W;
   localparam int CSR_ADDR_W = ssba_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = ssba_pkg::CSR_DATA_W;
   localparam int SLOT_REACH = ssba_pkg::SLOT_REACH;

   // Opcodes the package leaves unnamed; the block must answer them with an all-zero result.
   localparam logic [2:0] ACT_SPARE_6   = 3'd6;
   localparam logic [2:0] ACT_SPARE_7   = 3'd7;
   // Pause before a register write and at the end; covers the longest init.
   localparam int         SETTLE_CYCLES = 40;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   ssba_pkg::req_type     req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   ssba_pkg::rsp_type     rsp_payload;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   slab_slot_bitmap_allocator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor state: our own copy of the occupancy map and of both registers.
   logic [SLOT_REACH-1:0] slot_map         = '0;
   logic [LIMIT_W-1:0]    cfg_slot_count   = ssba_pkg::RST_SLOT_COUNT;
   logic [OBJ_W-1:0]      cfg_object_bytes = ssba_pkg::RST_OBJECT_BYTES;

   ssba_pkg::req_type request_q[$];   // requests waiting for the driver
   ssba_pkg::rsp_type outcome_q[$];   // predicted results, oldest first
   int                mismatch_count = 0;

   // Sender pacing and receiver stall pattern.
   int burst_left  = 0;
   int gap_left    = 0;
   int stall_mode  = 0;
   int mode_left   = 0;
   int hold_left   = 0;
   bit hold_value  = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   // Slots actually reachable: the register, capped by the map size and the 8-bit slot field.
   function automatic int slot_limit();
      int n;
      n = int'(cfg_slot_count);
      if (n > ssba_pkg::DEF_MAX_SLOTS) n = ssba_pkg::DEF_MAX_SLOTS;
      if (n > SLOT_REACH) n = SLOT_REACH;
      return n;
   endfunction

   // Apply one request to the map copy and return the result it must produce.
   function automatic ssba_pkg::rsp_type predict_outcome(input ssba_pkg::req_type r);
      ssba_pkg::rsp_type o;
      int                limit;
      int                obj;
      int                header;
      int                s;
      bit                want;
      o     = '0;
      limit = slot_limit();
      s     = int'(r.slot);
      case (r.action)
         ssba_pkg::ACT_INIT: begin
            // header slots hold the header bytes plus one byte per map word, rounded up
            obj    = (cfg_object_bytes == '0) ? 1 : int'(cfg_object_bytes);
            header = (ssba_pkg::DEF_HEADER_BYTES + (limit + ssba_pkg::WORD_BITS - 1)
                      / ssba_pkg::WORD_BITS + obj - 1) / obj;
            if (header > limit) header = limit;
            slot_map = '0;
            for (int i = 0; i < header; i++) slot_map[i] = 1'b1;
         end
         ssba_pkg::ACT_SET: begin
            if (s < limit) slot_map[s] = 1'b1;
         end
         ssba_pkg::ACT_CLEAR: begin
            // slot zero is never released; neither is a slot past the limit
            if (s == 0 || s >= limit) o.error = 1'b1;
            else slot_map[s] = 1'b0;
         end
         ssba_pkg::ACT_TEST: begin
            o.bit_value = (s < limit) && slot_map[s];
         end
         ssba_pkg::ACT_FIND_FREE, ssba_pkg::ACT_FIND_USED: begin
            // lowest matching slot below the limit; bits above it stay invisible
            want = (r.action == ssba_pkg::ACT_FIND_USED);
            for (int i = 0; i < limit; i++) begin
               if (slot_map[i] == want && !o.found) begin
                  o.found      = 1'b1;
                  o.found_slot = SLOT_W'(i);
               end
            end
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] expv,
                                       input logic [31:0] actv);
      if (actv !== expv) begin
         $error("%s: expected %0h, actual %0h", name, expv, actv);
         mismatch_count++;
      end
   endfunction

   // Driver: predict on every accepted request, then hold, advance or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = $urandom_range(1, 24);
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) outcome_q.push_back(predict_outcome(req_payload));
         // a stalled request stays on the bus untouched
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (request_q.size() > 0) begin
               req_valid   <= 1'b1;
               req_payload <= request_q.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  // end of burst: pick the next gap, now and then a long gap-free stretch
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                  burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare every accepted result with the oldest prediction, and stall on
   // a pattern that switches between no stall, light, heavy and long runs.
   always @(posedge clock) begin
      ssba_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_q.size() == 0) begin
            $error("result with no request outstanding: %p", rsp_payload);
            mismatch_count++;
         end else begin
            exp_rsp = outcome_q.pop_front();
            check_field("bit_value", 32'(exp_rsp.bit_value), 32'(rsp_payload.bit_value));
            check_field("found", 32'(exp_rsp.found), 32'(rsp_payload.found));
            check_field("found_slot", 32'(exp_rsp.found_slot), 32'(rsp_payload.found_slot));
            check_field("error", 32'(exp_rsp.error), 32'(rsp_payload.error));
         end
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(10, 200);
      end
      mode_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: begin
            if (hold_left == 0) begin
               hold_value = 1'($urandom_range(0, 1));
               hold_left  = $urandom_range(1, 20);
            end
            hold_left--;
            rsp_stall <= hold_value;
         end
      endcase
   end

   // Block until every queued request is taken and answered, then let the core settle.
   task automatic wait_idle();
      do @(posedge clock);
      while (request_q.size() != 0 || req_valid || outcome_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register through setup and access, then read it back.
   task automatic csr_write(input ssba_pkg::csr_index_type idx,
                            input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] mask;
      string                 name;
      if (idx == ssba_pkg::CSR_SLOT_COUNT) begin
         mask = (CSR_DATA_W'(1) << LIMIT_W) - CSR_DATA_W'(1);
         name = "slot_count";
      end else begin
         mask = (CSR_DATA_W'(1) << OBJ_W) - CSR_DATA_W'(1);
         name = "object_bytes";
      end
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == ssba_pkg::CSR_SLOT_COUNT) cfg_slot_count = value[LIMIT_W-1:0];
      else cfg_object_bytes = value[OBJ_W-1:0];
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field(name, value & mask, csr_prdata & mask);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic push_request(input logic [2:0] act, input logic [SLOT_W-1:0] slot);
      ssba_pkg::req_type r;
      r.action = act;
      r.slot   = slot;
      request_q.push_back(r);
   endtask

   // Mostly in-range slot operations, with runs over neighboring slots so the searches
   // have to walk across word boundaries; the rest is init, spare opcodes and wild slots.
   task automatic queue_random_requests(input int count);
      int                made;
      int                pick;
      int                run;
      int                start;
      int                limit;
      logic [2:0]        act;
      logic [SLOT_W-1:0] slot;
      limit = slot_limit();
      made  = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         if (limit > 0 && $urandom_range(0, 4) != 0) slot = SLOT_W'($urandom_range(0, limit - 1));
         else slot = SLOT_W'($urandom_range(0, 255));
         if (pick < 8) begin
            run   = $urandom_range(1, 40);
            start = int'(slot);
            act   = $urandom_range(0, 2) != 0 ? ssba_pkg::ACT_SET : ssba_pkg::ACT_CLEAR;
            for (int k = 0; k < run; k++) push_request(act, SLOT_W'(start + k));
            push_request(ssba_pkg::ACT_FIND_FREE, SLOT_W'($urandom_range(0, 255)));
            push_request(ssba_pkg::ACT_FIND_USED, SLOT_W'($urandom_range(0, 255)));
            made += run + 2;
         end else begin
            if (pick < 13) act = ssba_pkg::ACT_INIT;
            else if (pick < 16) act = $urandom_range(0, 1) ? ACT_SPARE_7 : ACT_SPARE_6;
            else if (pick < 38) act = ssba_pkg::ACT_SET;
            else if (pick < 56) act = ssba_pkg::ACT_CLEAR;
            else if (pick < 74) act = ssba_pkg::ACT_TEST;
            else if (pick < 87) act = ssba_pkg::ACT_FIND_FREE;
            else act = ssba_pkg::ACT_FIND_USED;
            push_request(act, slot);
            made++;
         end
      end
   endtask

   // Reconfigure while idle, poke the limit edges, then run random traffic.
   task automatic run_phase(input logic [LIMIT_W-1:0] sc, input logic [OBJ_W-1:0] ob,
                            input bit with_init, input int count);
      int limit;
      wait_idle();
      csr_write(ssba_pkg::CSR_SLOT_COUNT, CSR_DATA_W'(sc));
      csr_write(ssba_pkg::CSR_OBJECT_BYTES, CSR_DATA_W'(ob));
      limit = slot_limit();
      if (with_init) push_request(ssba_pkg::ACT_INIT, '0);
      push_request(ssba_pkg::ACT_FIND_FREE, '0);
      push_request(ssba_pkg::ACT_FIND_USED, '0);
      push_request(ssba_pkg::ACT_SET, SLOT_W'(limit));
      push_request(ssba_pkg::ACT_TEST, SLOT_W'(limit));
      push_request(ssba_pkg::ACT_CLEAR, SLOT_W'(limit));
      push_request(ssba_pkg::ACT_CLEAR, '0);
      queue_random_requests(count);
   endtask

   initial begin
      int sc;
      int ob;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed pass at the reset configuration: empty map, header marking, refused
      // clear of slot zero, top slot, spare opcodes and both searches.
      push_request(ssba_pkg::ACT_FIND_FREE, '0);
      push_request(ssba_pkg::ACT_FIND_USED, 8'hFF);
      push_request(ssba_pkg::ACT_INIT, 8'hFF);
      push_request(ssba_pkg::ACT_TEST, 8'd0);
      push_request(ssba_pkg::ACT_TEST, 8'd1);
      push_request(ssba_pkg::ACT_TEST, 8'd2);
      push_request(ssba_pkg::ACT_FIND_FREE, '0);
      push_request(ssba_pkg::ACT_SET, 8'd255);
      push_request(ssba_pkg::ACT_TEST, 8'd255);
      push_request(ssba_pkg::ACT_CLEAR, 8'd0);
      push_request(ssba_pkg::ACT_CLEAR, 8'd1);
      push_request(ssba_pkg::ACT_FIND_FREE, '0);
      push_request(ssba_pkg::ACT_SET, 8'd128);
      push_request(ssba_pkg::ACT_CLEAR, 8'd255);
      push_request(ACT_SPARE_6, 8'hFF);
      push_request(ACT_SPARE_7, 8'h00);
      push_request(ssba_pkg::ACT_CLEAR, 8'd0);
      push_request(ssba_pkg::ACT_FIND_USED, '0);
      push_request(ssba_pkg::ACT_CLEAR, 8'd128);
      push_request(ssba_pkg::ACT_FIND_USED, '0);

      // Register extremes, then a lowered limit over a dirty map, then random settings.
      run_phase(9'd0, 16'd0, 1'b1, 40);
      run_phase(9'd1, 16'd1, 1'b1, 100);
      run_phase(9'd511, 16'd65535, 1'b1, 150);
      run_phase(9'd256, 16'd1, 1'b1, 150);
      run_phase(9'd40, 16'd1, 1'b0, 100);
      run_phase(9'd33, 16'd3, 1'b1, 150);
      run_phase(9'd32, 16'd72, 1'b1, 100);
      repeat (6) begin
         sc = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 256);
         ob = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 80);
         run_phase(LIMIT_W'(sc), OBJ_W'(ob), $urandom_range(0, 3) != 0, 120);
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("slab_slot_bitmap_allocator_core regression: pass");
      end else begin
         $display("slab_slot_bitmap_allocator_core regression: fail");
      end
      $finish;
   end

   // Watchdog: a correct run finishes far sooner.
   initial begin
      #2ms;
      $display("slab_slot_bitmap_allocator_core regression: fail");
      $finish;
   end

endmodule
